// ===== hdl/csv_pkg.sv =====
// ----------------------------------------------------------------------------
// csv_pkg
// Shared types and constants for the cluster stream validator.
// ----------------------------------------------------------------------------
package csv_pkg;

  localparam logic [31:0] MAGIC_NATIVE  = 32'h12345678;
  localparam logic [31:0] MAGIC_SWAPPED = 32'h78563412;
  localparam logic [31:0] LVDS_HDR_MASK = 32'hf0000000;
  localparam logic [31:0] LVDS_HDR_TAG  = 32'h80000000;
  localparam logic [27:0] LVDS_LEN_MASK = 28'h0fffffff;
  localparam logic [31:0] SUBEV_LVDS    = 32'd1;
  localparam logic [31:0] SUBEV_TS      = 32'd100;

  localparam int unsigned NUM_CFG = 7;
  localparam logic [2:0] CFG_LEVEL   = 3'd0;
  localparam logic [2:0] CFG_EVENTS  = 3'd1;
  localparam logic [2:0] CFG_VED     = 3'd2;
  localparam logic [2:0] CFG_TEXT    = 3'd3;
  localparam logic [2:0] CFG_FILE    = 3'd4;
  localparam logic [2:0] CFG_ASYNC2  = 3'd5;
  localparam logic [2:0] CFG_NO_MORE = 3'd6;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_END = 4'd1, ST_MAGIC = 4'd2, ST_LENGTH = 4'd3,
    ST_TRUNC = 4'd4, ST_SHORT = 4'd5, ST_TYPE = 4'd6, ST_OPTIONS = 4'd7,
    ST_EVHEAD = 4'd8, ST_EVENT = 4'd9, ST_SUBEV = 4'd10, ST_LVDS = 4'd11,
    ST_TSSIZE = 4'd12, ST_EVLEFT = 4'd13, ST_CLLEFT = 4'd14
  } status_t;

  typedef enum logic [20:0] {
    PH_LEN       = 21'h000001, PH_MAGIC  = 21'h000002, PH_TYPE  = 21'h000004,
    PH_OSIZE     = 21'h000008, PH_OFLAGS = 21'h000010, PH_OSKIP = 21'h000020,
    PH_REST      = 21'h000040, PH_EH0    = 21'h000080, PH_EH1   = 21'h000100,
    PH_EH2       = 21'h000200, PH_EH3    = 21'h000400, PH_E0    = 21'h000800,
    PH_E1        = 21'h001000, PH_E2     = 21'h002000, PH_E3    = 21'h004000,
    PH_SID       = 21'h008000, PH_SSIZE_LVD = 21'h010000,
    PH_SSIZE_TS  = 21'h020000, PH_TS     = 21'h040000, PH_LHEAD = 21'h080000,
    PH_LBODY     = 21'h100000
  } phase_t;

  typedef struct packed {
    logic [1:0]  level;
    logic [31:0] type_events;
    logic [31:0] type_ved_info;
    logic [31:0] type_text;
    logic [31:0] type_file;
    logic [31:0] type_async2;
    logic [31:0] type_no_more;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] record_number;
    logic [31:0] record_words;
    logic        swapped;
    logic [31:0] event_count;
    logic [31:0] total_words;
  } result_t;

  function automatic logic [31:0] bswap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ===== hdl/csv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// csv_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module csv_cfg_regs
  import csv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level         <= 2'd2;
      cfg.type_events   <= 32'd0;
      cfg.type_ved_info <= 32'd1;
      cfg.type_text     <= 32'd2;
      cfg.type_file     <= 32'd3;
      cfg.type_async2   <= 32'd4;
      cfg.type_no_more  <= 32'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVEL:   cfg.level         <= cfg_data[1:0];
        CFG_EVENTS:  cfg.type_events   <= cfg_data;
        CFG_VED:     cfg.type_ved_info <= cfg_data;
        CFG_TEXT:    cfg.type_text     <= cfg_data;
        CFG_FILE:    cfg.type_file     <= cfg_data;
        CFG_ASYNC2:  cfg.type_async2   <= cfg_data;
        CFG_NO_MORE: cfg.type_no_more  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/csv_walker.sv =====
// ----------------------------------------------------------------------------
// csv_walker
// Record parser: one word per cycle, all checks in one combinational pass.
// ----------------------------------------------------------------------------
module csv_walker
  import csv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_fire,
  input  logic        in_op,
  input  logic [31:0] in_word,
  output logic        res_valid,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic        halted, halted_next;
  logic        swap_flag, swap_flag_next;
  logic        is_events, is_events_next;
  logic [31:0] first_word, first_word_next;
  logic [31:0] record_left, record_left_next;
  logic [31:0] options_left, options_left_next;
  logic [31:0] events_left, events_left_next;
  logic [31:0] event_left, event_left_next;
  logic [31:0] subevents_left, subevents_left_next;
  logic [31:0] subevent_left, subevent_left_next;
  logic [27:0] lvds_left, lvds_left_next;
  logic [31:0] record_count, record_count_next;
  logic [31:0] word_count, word_count_next;
  logic [31:0] events_in_record, events_in_record_next;

  always_comb begin
    logic        emit, with_rec, fail_f, ok_f;
    logic [3:0]  st;
    logic [31:0] w, r, rl, size, ol, sl, n32;
    logic [27:0] n;
    // follow-on actions
    logic do_opts, do_sub, adv_event, do_lvd;
    phase_t      ph_at_put;

    phase_next = phase; halted_next = halted; swap_flag_next = swap_flag;
    is_events_next = is_events; first_word_next = first_word;
    record_left_next = record_left; options_left_next = options_left;
    events_left_next = events_left; event_left_next = event_left;
    subevents_left_next = subevents_left; subevent_left_next = subevent_left;
    lvds_left_next = lvds_left; record_count_next = record_count;
    word_count_next = word_count; events_in_record_next = events_in_record;
    emit = 1'b0; with_rec = 1'b1; fail_f = 1'b0; ok_f = 1'b0; st = ST_OK;
    do_opts = 1'b0; do_sub = 1'b0; adv_event = 1'b0; do_lvd = 1'b0;
    w = swap_flag ? bswap32(in_word) : in_word;
    r = record_left; rl = r - 32'd1; size = 32'd0; ol = 32'd0; sl = 32'd0;
    n = in_word[27:0]; n32 = 32'd0;
    ph_at_put = phase;

    if (in_fire && !halted) begin
      if (in_op) begin
        emit = 1'b1; halted_next = 1'b1;
        if (cfg.level == 2'd0) begin
          st = ST_END; with_rec = 1'b0;
        end else if (phase == PH_LEN) begin
          st = ST_END;
        end else begin
          st = ST_TRUNC;
        end
      end else begin
        if (word_count != 32'hffffffff) word_count_next = word_count + 32'd1;
        if (cfg.level != 2'd0) begin
          case (phase)
            PH_LEN: begin
              first_word_next = in_word;
              record_count_next = record_count + 32'd1;
              swap_flag_next = 1'b0;
              events_in_record_next = 32'd0;
              phase_next = PH_MAGIC;
            end
            PH_MAGIC: begin
              if (in_word == MAGIC_NATIVE || in_word == MAGIC_SWAPPED) begin
                swap_flag_next = (in_word == MAGIC_SWAPPED);
                size = (in_word == MAGIC_SWAPPED) ? bswap32(first_word) : first_word;
                phase_next = PH_REST;
                ph_at_put = PH_REST;
                if (size == 32'd0 || size == 32'hffffffff) begin
                  fail_f = 1'b1; st = ST_LENGTH;
                end else begin
                  record_left_next = size - 32'd1;
                  if (cfg.level == 2'd1) begin
                    if (size == 32'd1) ok_f = 1'b1;
                  end else if (size < 32'd2) begin
                    fail_f = 1'b1; st = ST_SHORT;
                  end else begin
                    phase_next = PH_TYPE;
                  end
                end
              end else begin
                fail_f = 1'b1; st = ST_MAGIC;
              end
            end
            default: begin
              record_left_next = rl;
              case (phase)
                PH_REST: if (rl == 32'd0) ok_f = 1'b1;
                PH_TYPE: begin
                  if (w == cfg.type_events || w == cfg.type_ved_info ||
                      w == cfg.type_text || w == cfg.type_file ||
                      w == cfg.type_async2 || w == cfg.type_no_more) begin
                    is_events_next = (w == cfg.type_events);
                    if (rl == 32'd0) begin
                      fail_f = 1'b1; st = ST_OPTIONS;
                    end else phase_next = PH_OSIZE;
                  end else begin
                    fail_f = 1'b1; st = ST_TYPE;
                  end
                end
                PH_OSIZE: begin
                  if (w > rl) begin
                    fail_f = 1'b1; st = ST_OPTIONS;
                  end else if (w == 32'd0) do_opts = 1'b1;
                  else begin
                    options_left_next = w; phase_next = PH_OFLAGS;
                  end
                end
                PH_OFLAGS: begin
                  ol = options_left - 32'd1;
                  options_left_next = ol;
                  if ((w[0] && ol < 32'd2) || (w[31:2] != 30'd0) || w[1]) begin
                    fail_f = 1'b1; st = ST_OPTIONS;
                  end else if (ol == 32'd0) do_opts = 1'b1;
                  else phase_next = PH_OSKIP;
                end
                PH_OSKIP: begin
                  ol = options_left - 32'd1;
                  options_left_next = ol;
                  if (ol == 32'd0) do_opts = 1'b1;
                end
                PH_EH0: if (w != 32'd0) begin
                  fail_f = 1'b1; st = ST_EVHEAD;
                end else phase_next = PH_EH1;
                PH_EH2: if (w != 32'd0) begin
                  fail_f = 1'b1; st = ST_EVHEAD;
                end else phase_next = PH_EH3;
                PH_EH1: phase_next = PH_EH2;
                PH_EH3: begin
                  events_left_next = w; adv_event = 1'b1;
                end
                PH_E0: begin
                  if ({1'b0, w} + 33'd1 > {1'b0, r}) begin
                    fail_f = 1'b1; st = ST_EVENT;
                  end else begin
                    event_left_next = w - 32'd3; phase_next = PH_E1;
                  end
                end
                PH_E1: phase_next = PH_E2;
                PH_E2: phase_next = PH_E3;
                PH_E3: begin
                  subevents_left_next = w; do_sub = 1'b1;
                end
                PH_SID: begin
                  event_left_next = event_left - 32'd1;
                  if (w == SUBEV_LVDS) phase_next = PH_SSIZE_LVD;
                  else if (w == SUBEV_TS) phase_next = PH_SSIZE_TS;
                  else begin
                    fail_f = 1'b1; st = ST_SUBEV;
                  end
                end
                PH_SSIZE_LVD, PH_SSIZE_TS: begin
                  event_left_next = event_left - 32'd1;
                  if (w > rl) begin
                    fail_f = 1'b1; st = ST_SUBEV;
                  end else begin
                    subevent_left_next = w;
                    if (phase == PH_SSIZE_TS) begin
                      if (w != 32'd2) begin
                        fail_f = 1'b1; st = ST_TSSIZE;
                      end else phase_next = PH_TS;
                    end else if (w == 32'd0) do_sub = 1'b1;
                    else phase_next = PH_LHEAD;
                  end
                end
                PH_TS: begin
                  event_left_next = event_left - 32'd1;
                  sl = subevent_left - 32'd1;
                  subevent_left_next = sl;
                  if (sl == 32'd0) do_sub = 1'b1;
                end
                PH_LHEAD: begin
                  event_left_next = event_left - 32'd1;
                  n = w[27:0] & LVDS_LEN_MASK;
                  n32 = {6'd0, n[27:2]};
                  if ((w & LVDS_HDR_MASK) != LVDS_HDR_TAG || n[1:0] != 2'd0 ||
                      n32 == 32'd0 || n32 > subevent_left) begin
                    fail_f = 1'b1; st = ST_LVDS;
                  end else begin
                    subevent_left_next = subevent_left - n32;
                    lvds_left_next = n32[27:0] - 28'd1;
                    if (n32 != 32'd1) phase_next = PH_LBODY;
                    else do_lvd = 1'b1;
                  end
                end
                PH_LBODY: begin
                  event_left_next = event_left - 32'd1;
                  lvds_left_next = lvds_left - 28'd1;
                  if (lvds_left == 28'd1) do_lvd = 1'b1;
                end
                default: phase_next = PH_REST;
              endcase
            end
          endcase

          // chained completions
          if (do_lvd) begin
            if (subevent_left_next == 32'd0) do_sub = 1'b1;
            else phase_next = PH_LHEAD;
          end
          if (do_sub) begin
            if (subevents_left_next == 32'd0) begin
              if (event_left_next != 32'd0) begin
                fail_f = 1'b1; st = ST_EVLEFT;
              end else adv_event = 1'b1;
            end else begin
              subevents_left_next = subevents_left_next - 32'd1;
              if (rl < 32'd2) begin
                fail_f = 1'b1; st = ST_SUBEV;
              end else phase_next = PH_SID;
            end
          end
          if (adv_event) begin
            if (events_left_next == 32'd0) begin
              if (rl != 32'd0) begin
                fail_f = 1'b1; st = ST_CLLEFT;
              end else ok_f = 1'b1;
            end else begin
              events_left_next = events_left_next - 32'd1;
              if (rl < 32'd4) begin
                fail_f = 1'b1; st = ST_EVENT;
              end else begin
                events_in_record_next = events_in_record + 32'd1;
                phase_next = PH_E0;
              end
            end
          end
          if (do_opts) begin
            if (is_events_next) begin
              if (rl < 32'd4) begin
                fail_f = 1'b1; st = ST_EVHEAD;
              end else phase_next = PH_EH0;
            end else if (rl == 32'd0) ok_f = 1'b1;
            else phase_next = PH_REST;
          end

          if (fail_f) begin
            emit = 1'b1; halted_next = 1'b1;
          end else if (ok_f) begin
            emit = 1'b1; st = ST_OK; phase_next = PH_LEN;
          end
        end
      end
    end

    res_valid = emit;
    res.status = st;
    res.record_number = record_count_next;
    res.total_words = word_count_next;
    if (with_rec && ph_at_put != PH_LEN && ph_at_put != PH_MAGIC) begin
      res.record_words = (swap_flag_next ? bswap32(first_word_next)
                                         : first_word_next) + 32'd1;
      res.swapped = swap_flag_next;
      res.event_count = events_in_record_next;
    end else begin
      res.record_words = 32'd0;
      res.swapped = 1'b0;
      res.event_count = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEN; halted <= 1'b0; swap_flag <= 1'b0; is_events <= 1'b0;
      first_word <= '0; record_left <= '0; options_left <= '0;
      events_left <= '0; event_left <= '0; subevents_left <= '0;
      subevent_left <= '0; lvds_left <= '0; record_count <= '0;
      word_count <= '0; events_in_record <= '0;
    end else begin
      phase <= phase_next; halted <= halted_next; swap_flag <= swap_flag_next;
      is_events <= is_events_next;
      first_word <= first_word_next; record_left <= record_left_next;
      options_left <= options_left_next; events_left <= events_left_next;
      event_left <= event_left_next; subevents_left <= subevents_left_next;
      subevent_left <= subevent_left_next; lvds_left <= lvds_left_next;
      record_count <= record_count_next; word_count <= word_count_next;
      events_in_record <= events_in_record_next;
    end
  end

endmodule

// ===== hdl/csv_out_buf.sv =====
// ----------------------------------------------------------------------------
// csv_out_buf
// Two-entry output skid buffer for result transactions.
// ----------------------------------------------------------------------------
module csv_out_buf
  import csv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  result_t wr_data,
  output logic    space,
  output logic    valid,
  input  logic    ready,
  output result_t data
);

  result_t mem [2];
  logic    wp, rp;
  logic [1:0] cnt;

  assign valid = (cnt != 2'd0);
  // full only blocks when the head is not leaving this cycle
  assign space = (cnt != 2'd2) || ready;
  assign data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (valid && ready) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, valid && ready};
    end
  end

endmodule

// ===== hdl/cluster_stream_validator_top.sv =====
// ----------------------------------------------------------------------------
// cluster_stream_validator_top
// Validates a stream of cluster record words, one word per transaction.
// ----------------------------------------------------------------------------
// A result is formed combinationally and held in the result buffer.
// Throughput: one word per cycle while in_ready is high; one-pass update.
// in_ready drops only while the two-entry result buffer could overflow.
// Reset (rst, synchronous): parser back to length-word phase, counters and
// result buffer cleared, registers at their defaults.
module cluster_stream_validator_top
  import csv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // word stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] word,
  // result stream out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [31:0] record_number,
  output logic [31:0] record_words,
  output logic        swapped,
  output logic [31:0] event_count,
  output logic [31:0] total_words
);

  cfg_t    cfg;
  result_t res, out_res;
  logic    res_valid, in_fire, space;

  csv_cfg_regs u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  // accept a word whenever a result produced by it would still fit
  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  csv_walker u_walk (
    .clk, .rst, .cfg, .in_fire, .in_op(op), .in_word(word),
    .res_valid, .res
  );

  // results leave via a small FIFO so a stall on the output never loses one
  csv_out_buf u_buf (
    .clk, .rst, .wr(res_valid), .wr_data(res), .space,
    .valid(out_valid), .ready(out_ready), .data(out_res)
  );

  assign status        = out_res.status;
  assign record_number = out_res.record_number;
  assign record_words  = out_res.record_words;
  assign swapped       = out_res.swapped;
  assign event_count   = out_res.event_count;
  assign total_words   = out_res.total_words;

endmodule

// ===== dv/tb_cluster_stream_validator_top.sv =====
// ----------------------------------------------------------------------------
// tb_cluster_stream_validator_top
// Self-checking bench for the cluster stream validator: builds well-formed
// cluster records at all check levels, sends them through the word channel
// under random bursts and output stalls, and compares each result against
// a cycle-free parser model. The run closes with one injected fault.
// ----------------------------------------------------------------------------
module tb_cluster_stream_validator_top;
  import csv_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_LEVEL;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = 1'b0;
  logic [31:0] word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [31:0] record_number, record_words, event_count, total_words;
  logic        swapped;

  cluster_stream_validator_top uut (.*);

  // ---------------------------------------------------------------------------
  // clock, reset
  // ---------------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser model state; mirrors the register file and the record walker
  // ---------------------------------------------------------------------------
  logic [1:0]  lvl_cfg = 2'd2;
  logic [31:0] type_code [1:6] = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5};
  phase_t      ph = PH_LEN;
  bit          halted_m, swap_m, is_events;
  logic [31:0] first_w, rec_left, opt_left, evs_left, ev_left, subs_left, sub_left;
  logic [27:0] lvds_left_m;
  logic [31:0] rec_cnt, word_cnt, ev_in_rec;

  result_t     pending_results [$];
  int          error_count, results_seen, records_passed, words_sent, burst_left;
  int          hold_req;

  initial begin
    {halted_m, swap_m, is_events} = '0;
    {first_w, rec_left, opt_left, evs_left, ev_left, subs_left, sub_left} = '0;
    {lvds_left_m, rec_cnt, word_cnt, ev_in_rec} = '0;
  end

  function automatic logic [31:0] byte_rev(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic void emit(input status_t st, input bit with_rec);
    result_t r;
    r = '0;
    r.status        = st;
    r.record_number = rec_cnt;
    r.total_words   = word_cnt;
    // record fields only exist once the magic word has been taken
    if (with_rec && ph != PH_LEN && ph != PH_MAGIC) begin
      r.record_words = (swap_m ? byte_rev(first_w) : first_w) + 32'd1;
      r.swapped      = swap_m;
      r.event_count  = ev_in_rec;
    end
    pending_results.push_back(r);
  endfunction

  function automatic void abort_record(input status_t st);
    emit(st, 1'b1);
    halted_m = 1'b1;
  endfunction

  function automatic void record_done();
    emit(ST_OK, 1'b1);
    ph = PH_LEN;
    records_passed++;
  endfunction

  function automatic void next_event();
    if (evs_left == 0) begin
      if (rec_left != 0) abort_record(ST_CLLEFT);
      else record_done();
      return;
    end
    evs_left--;
    if (rec_left < 4) begin
      abort_record(ST_EVENT);
      return;
    end
    ev_in_rec++;
    ph = PH_E0;
  endfunction

  function automatic void next_subevent();
    if (subs_left == 0) begin
      if (ev_left != 0) abort_record(ST_EVLEFT);
      else next_event();
      return;
    end
    subs_left--;
    if (rec_left < 2) abort_record(ST_SUBEV);
    else ph = PH_SID;
  endfunction

  function automatic void lvds_block_done();
    if (sub_left == 0) next_subevent();
    else ph = PH_LHEAD;
  endfunction

  function automatic void options_done();
    if (is_events) begin
      if (rec_left < 4) abort_record(ST_EVHEAD);
      else ph = PH_EH0;
    end else if (rec_left == 0) begin
      record_done();
    end else begin
      ph = PH_REST;
    end
  endfunction

  // one accepted transaction into the model; results go to pending_results
  function automatic void parse_word(input bit eos, input logic [31:0] raw);
    logic [31:0] w, r, sz;
    logic [27:0] n;
    logic [1:0]  lvl;
    if (halted_m) return;
    w   = raw;
    lvl = lvl_cfg;
    if (eos) begin
      if (lvl == 0) emit(ST_END, 1'b0);
      else if (ph == PH_LEN) emit(ST_END, 1'b1);
      else emit(ST_TRUNC, 1'b1);
      halted_m = 1'b1;
      return;
    end
    if (word_cnt != 32'hffffffff) word_cnt++;
    if (lvl == 0) return;

    if (ph == PH_LEN) begin
      first_w   = w;
      rec_cnt++;
      swap_m    = 1'b0;
      ev_in_rec = '0;
      ph        = PH_MAGIC;
      return;
    end
    if (ph == PH_MAGIC) begin
      if (w == MAGIC_NATIVE) swap_m = 1'b0;
      else if (w == MAGIC_SWAPPED) swap_m = 1'b1;
      else begin
        abort_record(ST_MAGIC);
        return;
      end
      sz = swap_m ? byte_rev(first_w) : first_w;
      ph = PH_REST;
      if (sz == 0 || sz == 32'hffffffff) begin
        abort_record(ST_LENGTH);
        return;
      end
      rec_left = sz - 1;
      if (lvl == 1) begin
        if (rec_left == 0) record_done();
      end else if (sz < 2) begin
        abort_record(ST_SHORT);
      end else begin
        ph = PH_TYPE;
      end
      return;
    end

    if (swap_m) w = byte_rev(w);
    r        = rec_left;
    rec_left = r - 1;
    case (ph)
      PH_REST: begin
        if (rec_left == 0) record_done();
      end
      PH_TYPE: begin
        // events code wins a collision
        if (w == type_code[CFG_EVENTS]) is_events = 1'b1;
        else if (w == type_code[CFG_VED] || w == type_code[CFG_TEXT] ||
                 w == type_code[CFG_FILE] || w == type_code[CFG_ASYNC2] ||
                 w == type_code[CFG_NO_MORE]) is_events = 1'b0;
        else begin
          abort_record(ST_TYPE);
          return;
        end
        if (rec_left == 0) abort_record(ST_OPTIONS);
        else ph = PH_OSIZE;
      end
      PH_OSIZE: begin
        if (w > rec_left) abort_record(ST_OPTIONS);
        else if (w == 0) options_done();
        else begin
          opt_left = w;
          ph = PH_OFLAGS;
        end
      end
      PH_OFLAGS: begin
        opt_left--;
        if ((w[0] && opt_left < 2) || (w & ~32'd3) != 0 || w[1])
          abort_record(ST_OPTIONS);
        else if (opt_left == 0) options_done();
        else ph = PH_OSKIP;
      end
      PH_OSKIP: begin
        opt_left--;
        if (opt_left == 0) options_done();
      end
      PH_EH0: begin
        if (w != 0) abort_record(ST_EVHEAD);
        else ph = PH_EH1;
      end
      PH_EH1: ph = PH_EH2;
      PH_EH2: begin
        if (w != 0) abort_record(ST_EVHEAD);
        else ph = PH_EH3;
      end
      PH_EH3: begin
        evs_left = w;
        next_event();
      end
      PH_E0: begin
        if ({1'b0, w} + 33'd1 > {1'b0, r}) begin
          abort_record(ST_EVENT);
          return;
        end
        ev_left = w - 3;
        ph = PH_E1;
      end
      PH_E1: ph = PH_E2;
      PH_E2: ph = PH_E3;
      PH_E3: begin
        subs_left = w;
        next_subevent();
      end
      PH_SID: begin
        ev_left--;
        if (w == SUBEV_LVDS) ph = PH_SSIZE_LVD;
        else if (w == SUBEV_TS) ph = PH_SSIZE_TS;
        else abort_record(ST_SUBEV);
      end
      PH_SSIZE_LVD, PH_SSIZE_TS: begin
        ev_left--;
        if (w > rec_left) begin
          abort_record(ST_SUBEV);
          return;
        end
        sub_left = w;
        if (ph == PH_SSIZE_TS) begin
          if (w != 2) abort_record(ST_TSSIZE);
          else ph = PH_TS;
        end else if (w == 0) next_subevent();
        else ph = PH_LHEAD;
      end
      PH_TS: begin
        ev_left--;
        sub_left--;
        if (sub_left == 0) next_subevent();
      end
      PH_LHEAD: begin
        ev_left--;
        n = w[27:0];
        if ((w & LVDS_HDR_MASK) != LVDS_HDR_TAG || n[1:0] != 0) begin
          abort_record(ST_LVDS);
          return;
        end
        n = n >> 2;
        // zero-length block would loop forever; flagged
        if (n == 0 || {4'd0, n} > sub_left) begin
          abort_record(ST_LVDS);
          return;
        end
        sub_left    = sub_left - {4'd0, n};
        lvds_left_m = n - 28'd1;
        if (lvds_left_m != 0) ph = PH_LBODY;
        else lvds_block_done();
      end
      PH_LBODY: begin
        ev_left--;
        lvds_left_m--;
        if (lvds_left_m == 0) lvds_block_done();
      end
      default: ph = PH_REST;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending, status %0d", status));
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status)
          report($sformatf("status %0d, want %0d", status, exp_r.status));
        if (record_number !== exp_r.record_number)
          report($sformatf("record_number %0d, want %0d", record_number,
                           exp_r.record_number));
        if (record_words !== exp_r.record_words)
          report($sformatf("record_words %0d, want %0d", record_words,
                           exp_r.record_words));
        if (swapped !== exp_r.swapped)
          report($sformatf("swapped %0b, want %0b", swapped, exp_r.swapped));
        if (event_count !== exp_r.event_count)
          report($sformatf("event_count %0d, want %0d", event_count,
                           exp_r.event_count));
        if (total_words !== exp_r.total_words)
          report($sformatf("total_words %0d, want %0d", total_words,
                           exp_r.total_words));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: rotating stall modes, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int rx_mode, rx_cyc, hold_left;
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) out_ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // sender: bursts with random gaps; call only at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input bit eos, input logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op       <= eos;
    word     <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    parse_word(eos, w);
  endtask

  task automatic send_record(input logic [31:0] rec [$], input bit swp);
    foreach (rec[i]) send_word(1'b0, swp ? byte_rev(rec[i]) : rec[i]);
  endtask

  // drain all pending results, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_LEVEL) lvl_cfg = v[1:0];
    else type_code[idx] = v;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // record builders (native byte order; length and magic prepended)
  // ---------------------------------------------------------------------------
  function automatic void frame(ref logic [31:0] q [$]);
    q.push_front(MAGIC_NATIVE);
    q.push_front(q.size());
  endfunction

  // kind: CFG_EVENTS for an events cluster, any other code index for
  // an options-only cluster of that type
  function automatic void build_cluster(ref logic [31:0] q [$], input int kind);
    logic [31:0] sub [$];
    int k, nev, nsub, nb, n, sz;
    q.delete();
    q.push_back(type_code[kind]);
    k = $urandom_range(0, 5);
    q.push_back(k);
    if (k > 0) begin
      q.push_back((k >= 3 && $urandom_range(0, 1)) ? 32'd1 : 32'd0);
      repeat (k - 1) q.push_back($urandom);
    end
    if (kind == CFG_EVENTS) begin
      q.push_back(0);
      q.push_back($urandom);
      q.push_back(0);
      nev = $urandom_range(0, 3);
      q.push_back(nev);
      repeat (nev) begin
        sub.delete();
        nsub = $urandom_range(0, 3);
        repeat (nsub) begin
          if ($urandom_range(0, 2) == 0) begin
            sub.push_back(SUBEV_TS);
            sub.push_back(2);
            sub.push_back($urandom);
            sub.push_back($urandom);
          end else begin
            // LVDS subevent, possibly with no blocks at all
            nb = $urandom_range(0, 3);
            sz = 0;
            sub.push_back(SUBEV_LVDS);
            sub.push_back(0);
            k = sub.size() - 1;
            repeat (nb) begin
              n = $urandom_range(1, 4);
              sub.push_back(LVDS_HDR_TAG | (n << 2));
              repeat (n - 1) sub.push_back($urandom);
              sz += n;
            end
            sub[k] = sz;
          end
        end
        q.push_back(3 + sub.size());
        q.push_back($urandom);
        q.push_back($urandom);
        q.push_back(nsub);
        foreach (sub[i]) q.push_back(sub[i]);
      end
    end else begin
      repeat ($urandom_range(0, 4)) q.push_back($urandom);
    end
    frame(q);
  endfunction

  function automatic void build_framed(ref logic [31:0] q [$], input int body);
    q.delete();
    repeat (body) q.push_back($urandom);
    frame(q);
  endfunction

  // send a record that suits the current level
  task automatic send_any(input int kind);
    logic [31:0] rec [$];
    if (lvl_cfg == 0) begin
      repeat ($urandom_range(3, 12)) send_word(1'b0, $urandom);
      return;
    end
    if (lvl_cfg == 1) build_framed(rec, $urandom_range(0, 6));
    else build_cluster(rec, kind);
    send_record(rec, $urandom_range(0, 1));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [31:0] rec [$];
    // every cluster type at default codes, native; an events one swapped
    for (int k = CFG_EVENTS; k <= CFG_NO_MORE; k++) begin
      build_cluster(rec, k);
      send_record(rec, 1'b0);
    end
    build_cluster(rec, CFG_EVENTS);
    send_record(rec, 1'b1);
    // extreme type codes, with ved info colliding with the events code
    wait_idle();
    write_reg(CFG_EVENTS, 32'hffffffff);
    write_reg(CFG_VED, 32'hffffffff);
    write_reg(CFG_TEXT, 32'h00000000);
    write_reg(CFG_FILE, 32'h80000000);
    write_reg(CFG_ASYNC2, 32'h7fffffff);
    write_reg(CFG_NO_MORE, 32'h0000ffff);
    build_cluster(rec, CFG_EVENTS);
    send_record(rec, 1'b0);
    for (int k = CFG_TEXT; k <= CFG_NO_MORE; k++) begin
      build_cluster(rec, k);
      send_record(rec, k[0]);
    end
    // framing only: one-word record closes on its magic
    wait_idle();
    write_reg(CFG_LEVEL, 32'd1);
    build_framed(rec, 0);
    send_record(rec, 1'b0);
    build_framed(rec, 0);
    send_record(rec, 1'b1);
    build_framed(rec, 3);
    send_record(rec, 1'b0);
    // count-only level, then level three behaves as full check
    wait_idle();
    write_reg(CFG_LEVEL, 32'd0);
    send_word(1'b0, 32'h00000000);
    send_word(1'b0, 32'hffffffff);
    wait_idle();
    write_reg(CFG_LEVEL, 32'd3);
    build_cluster(rec, CFG_EVENTS);
    send_record(rec, 1'b1);
    wait_idle();
    // back to distinct default codes so later clusters of any type pass
    for (int k = CFG_EVENTS; k <= CFG_NO_MORE; k++)
      write_reg(3'(k), 32'(k - 1));
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(CFG_LEVEL, 32'd1);
    hold_req = 300;
    repeat (40) send_any(0);
    wait_idle();
  endtask

  task automatic test_random();
    int base;
    while (words_sent < 1500) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_LEVEL, 32'd0);
        1, 2:    write_reg(CFG_LEVEL, 32'd1);
        3:       write_reg(CFG_LEVEL, 32'd3);
        default: write_reg(CFG_LEVEL, 32'd2);
      endcase
      if ($urandom_range(0, 2) == 0) begin
        // distinct codes, wrapping near the top now and then
        base = $urandom_range(0, 1) ? $urandom : 32'hfffffffc;
        for (int k = CFG_EVENTS; k <= CFG_NO_MORE; k++)
          write_reg(3'(k), 32'(base + k));
      end
      repeat ($urandom_range(4, 12))
        send_any($urandom_range(0, 1) ? CFG_EVENTS : $urandom_range(2, 6));
    end
    wait_idle();
  endtask

  // one fault at the end: it halts the block for the rest of the run
  task automatic test_final_fault();
    logic [31:0] rec [$];
    int idx, cut;
    write_reg(CFG_LEVEL, $urandom_range(0, 7) == 0 ? 32'd0 : 32'd2);
    build_cluster(rec, CFG_EVENTS);
    idx = $urandom_range(0, rec.size() - 1);
    cut = rec.size();
    case ($urandom_range(0, 4))
      0: rec[idx] = $urandom;
      1: rec[idx] = rec[idx] ^ (32'd1 << $urandom_range(0, 31));
      2: cut = $urandom_range(1, rec.size());
      3: rec[0] = $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
      default: rec[idx] = LVDS_HDR_TAG;
    endcase
    while (rec.size() > cut) void'(rec.pop_back());
    send_record(rec, $urandom_range(0, 1));
    send_word(1'b1, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_final_fault();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d words, %0d records closed cleanly, %0d results checked",
             words_sent, records_passed, results_seen);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 2000000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
